// ----- hw/rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, constants and helpers of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   localparam int KEY_W          = 64;
   localparam int VAL_W          = 64;
   localparam int LEN_W          = 4;
   localparam int CAP_W          = 5;
   localparam int CAP_RESET      = 16;
   localparam int ENTRIES_DEF    = 16;
   localparam int KEY_BYTES_DEF  = 8;
   localparam int VAL_BYTES_DEF  = 8;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_ADD    = 2'd1,
      OP_DELETE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // normalized request as it travels from front to back
   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   key_len;
      logic [VAL_W-1:0]   value;
      logic [LEN_W-1:0]   value_len;
   } req_item_type;

   typedef struct packed {
      logic               hit;
      logic [VAL_W-1:0]   value;
      logic [LEN_W-1:0]   value_len;
      logic               evicted;
   } rsp_item_type;

   // ones in the low n bytes of a 64-bit word
   function automatic logic [63:0] byte_mask(input logic [LEN_W-1:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         m[8*b +: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lkv_front.sv -----
// ----------------------------------------------------------------------------
// lkv_front
// Takes requests, saturates lengths, masks unused bytes, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_front import lkv_pkg::*; #(
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int VALUE_BYTES = VAL_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [1:0]       req_type,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [LEN_W-1:0] req_key_length,
   input  wire logic [VAL_W-1:0] req_value,
   input  wire logic [LEN_W-1:0] req_value_length,
   output logic                  head_valid,
   output req_item_type          head_item,
   input  wire logic             head_pop
);

   req_item_type       norm;
   logic [LEN_W-1:0]   klen_sat;
   logic [LEN_W-1:0]   vlen_sat;
   req_item_type       q_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push_ok;

   // length saturation and byte masking
   always_comb begin
      klen_sat = (int'(req_key_length) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : req_key_length;
      vlen_sat = (int'(req_value_length) > VALUE_BYTES) ? LEN_W'(VALUE_BYTES)
                                                        : req_value_length;
      norm.op        = op_type'(req_type);
      norm.key       = req_key & byte_mask(klen_sat);
      norm.key_len   = klen_sat;
      norm.value     = req_value & byte_mask(vlen_sat);
      norm.value_len = vlen_sat;
   end

   assign req_full   = (count_ff == 2'd2);
   assign push_ok    = req_push && !req_full;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ head_pop;
      count_in  = count_ff + 2'(push_ok) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= norm;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lkv_back.sv -----
// ----------------------------------------------------------------------------
// lkv_back
// Entry store and LRU ranks. A lookup cycle compares the key with every
// entry; an update cycle applies the request and emits its result.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_back import lkv_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int VALUE_BYTES = VAL_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data,
   input  wire logic             in_valid,
   input  wire req_item_type     in_item,
   output logic                  in_pop,
   input  wire logic             out_room,
   output logic                  out_push,
   output rsp_item_type          out_item
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int KW = KEY_BYTES * 8;
   localparam int VW = VALUE_BYTES * 8;

   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_UPDATE} state_type;

   state_type          state_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [CW-1:0]      count_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [KW-1:0]      key_ff   [ENTRIES];
   logic [LEN_W-1:0]   klen_ff  [ENTRIES];
   logic [VW-1:0]      val_ff   [ENTRIES];
   logic [LEN_W-1:0]   vlen_ff  [ENTRIES];
   logic [IW-1:0]      rank_ff  [ENTRIES];

   // current request
   op_type             op_ff;
   logic [KW-1:0]      ckey_ff;
   logic [LEN_W-1:0]   cklen_ff;
   logic [VW-1:0]      cval_ff;
   logic [LEN_W-1:0]   cvlen_ff;

   // lookup results
   logic               hit_ff, hit_in;
   logic [IW-1:0]      midx_ff, midx_in;
   logic [IW-1:0]      free_ff, free_in;
   logic [IW-1:0]      lru_ff, lru_in;
   logic [VW-1:0]      rdval_ff;
   logic [LEN_W-1:0]   rdvlen_ff;

   logic               start;
   logic               fill;
   logic [IW-1:0]      mrank;
   logic [IW-1:0]      slot;
   int                 cap_eff;

   assign start  = in_valid && out_room && (state_ff == ST_IDLE || state_ff == ST_UPDATE);
   assign in_pop = start;

   // associative compare, free slot and least recent slot (first one wins)
   always_comb begin
      hit_in  = 1'b0;
      midx_in = '0;
      free_in = '0;
      lru_in  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && klen_ff[i] == cklen_ff && key_ff[i] == ckey_ff) begin
            hit_in  = 1'b1;
            midx_in = IW'(i);
         end
         if (!valid_ff[i]) begin
            free_in = IW'(i);
         end
         if (valid_ff[i] && CW'(rank_ff[i]) == count_ff - CW'(1)) begin
            lru_in = IW'(i);
         end
      end
   end

   // update decisions
   always_comb begin
      cap_eff = (cap_ff == '0) ? 1 : int'(cap_ff);
      fill    = (int'(count_ff) < ENTRIES) && (int'(count_ff) < cap_eff);
      slot    = fill ? free_ff : lru_ff;
      mrank   = rank_ff[midx_ff];
   end

   // result
   always_comb begin
      out_push          = (state_ff == ST_UPDATE);
      out_item.hit      = (op_ff != OP_NONE) && hit_ff;
      out_item.value    = (op_ff == OP_FIND && hit_ff) ? VAL_W'(rdval_ff) : '0;
      out_item.value_len = (op_ff == OP_FIND && hit_ff) ? rdvlen_ff : '0;
      out_item.evicted  = (op_ff == OP_ADD) && !hit_ff && !fill;
   end

   // sequencer, capacity register, valid bits and count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_W'(CAP_RESET);
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) state_ff <= ST_LOOKUP;
            end
            ST_LOOKUP: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               state_ff <= start ? ST_LOOKUP : ST_IDLE;
               if (op_ff == OP_ADD && !hit_ff) begin
                  valid_ff[slot] <= 1'b1;
                  if (fill) count_ff <= count_ff + CW'(1);
               end else if (op_ff == OP_DELETE && hit_ff) begin
                  valid_ff[midx_ff] <= 1'b0;
                  count_ff <= count_ff - CW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // request capture and lookup registers
   always_ff @(posedge clock) begin
      if (start) begin
         op_ff    <= in_item.op;
         ckey_ff  <= in_item.key[KW-1:0];
         cklen_ff <= in_item.key_len;
         cval_ff  <= in_item.value[VW-1:0];
         cvlen_ff <= in_item.value_len;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff    <= hit_in;
         midx_ff   <= midx_in;
         free_ff   <= free_in;
         lru_ff    <= lru_in;
         rdval_ff  <= val_ff[midx_in];
         rdvlen_ff <= vlen_ff[midx_in];
      end
   end

   // entry payload and recency ranks
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         case (op_ff)
            OP_FIND: begin
               if (hit_ff) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && rank_ff[i] < mrank) rank_ff[i] <= rank_ff[i] + IW'(1);
                  end
                  rank_ff[midx_ff] <= '0;
               end
            end
            OP_ADD: begin
               if (hit_ff) begin
                  val_ff[midx_ff]  <= cval_ff;
                  vlen_ff[midx_ff] <= cvlen_ff;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && IW'(i) != slot &&
                         (fill || CW'(rank_ff[i]) < count_ff - CW'(1))) begin
                        rank_ff[i] <= rank_ff[i] + IW'(1);
                     end
                  end
                  rank_ff[slot] <= '0;
                  key_ff[slot]  <= ckey_ff;
                  klen_ff[slot] <= cklen_ff;
                  val_ff[slot]  <= cval_ff;
                  vlen_ff[slot] <= cvlen_ff;
               end
            end
            OP_DELETE: begin
               if (hit_ff) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && rank_ff[i] > mrank) rank_ff[i] <= rank_ff[i] - IW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // occupancy tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) == $countones(valid_ff))
      else $error("entry count differs from valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ENTRIES)
      else $error("entry count above entry total");

   // a result follows its lookup cycle exactly
   a_push_after_lookup: assert property (@(posedge clock) disable iff (reset)
      out_push |-> $past(state_ff) == ST_LOOKUP)
      else $error("result without lookup");

   a_start_room: assert property (@(posedge clock) disable iff (reset)
      start |-> out_room)
      else $error("request started without result room");

endmodule

`default_nettype wire

// ----- hw/rtl/lkv_rspq.sv -----
// ----------------------------------------------------------------------------
// lkv_rspq
// Four-entry result queue; reports room while two more results fit.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_rspq import lkv_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output logic              room,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output rsp_item_type      head_item
);

   rsp_item_type q_ff [4];
   logic [1:0]   wr_ptr_ff;
   logic [1:0]   rd_ptr_ff;
   logic [2:0]   count_ff, count_in;
   logic         pop_ok;

   assign rsp_empty = (count_ff == 3'd0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign room      = (count_ff <= 3'd2);
   assign head_item = q_ff[rd_ptr_ff];
   assign count_in  = count_ff + 3'(push) - 3'(pop_ok);

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + 2'(push);
         rd_ptr_ff <= rd_ptr_ff + 2'(pop_ok);
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
//
// channel   direction  handshake               payload
// request   in         req_push / req_full     req_type, req_key(_length), req_value(_length)
// response  out        rsp_pop / rsp_empty     rsp_hit, rsp_value_out(_length_out), rsp_evicted
// csr       in         csr_wr_en               csr_wr_data (capacity)
//
// In the back end each request has a lookup step comparing all entries, then
// an update step applying the request and its recency change. The next
// request is taken in the update step of the one before, while the response
// queue has room. Synchronous reset empties the cache and sets capacity to 16.
// Requests queue (two deep) while the response queue is held.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache import lkv_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   parameter int VALUE_BYTES = VAL_BYTES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [1:0]       req_type,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [LEN_W-1:0] req_key_length,
   input  wire logic [VAL_W-1:0] req_value,
   input  wire logic [LEN_W-1:0] req_value_length,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic                  rsp_hit,
   output logic [VAL_W-1:0]      rsp_value_out,
   output logic [LEN_W-1:0]      rsp_value_length_out,
   output logic                  rsp_evicted,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   logic         head_valid;
   req_item_type head_item;
   logic         head_pop;
   logic         room;
   logic         rsp_push;
   rsp_item_type rsp_item;
   rsp_item_type rsp_head;

   // request normalization and queue
   lkv_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
      .clock, .reset, .req_push, .req_full, .req_type, .req_key, .req_key_length,
      .req_value, .req_value_length, .head_valid, .head_item, .head_pop
   );

   // lookup and update engine
   lkv_back #(.ENTRIES(ENTRIES), .KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_back (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .in_valid(head_valid), .in_item(head_item), .in_pop(head_pop),
      .out_room(room), .out_push(rsp_push), .out_item(rsp_item)
   );

   // response queue
   lkv_rspq u_rspq (
      .clock, .reset, .push(rsp_push), .push_item(rsp_item), .room,
      .rsp_empty, .rsp_pop, .head_item(rsp_head)
   );

   assign rsp_hit              = rsp_head.hit;
   assign rsp_value_out        = rsp_head.value;
   assign rsp_value_length_out = rsp_head.value_len;
   assign rsp_evicted          = rsp_head.evicted;

endmodule

`default_nettype wire
